### design/twcw_pkg.sv
package twcw_pkg;

  // Screen store geometry.
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 128;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

  // Largest effective window, the reach of the cursor fields.
  localparam logic [ROW_W:0] ROWS_LIMIT = 7'd64;
  localparam logic [COL_W:0] COLS_LIMIT = 8'd128;

  // Register reset values.
  localparam logic [7:0] SCREEN_COLS_RST = 8'd80;
  localparam logic [5:0] WIN_ROW_ORG_RST = 6'd0;
  localparam logic [6:0] WIN_COL_ORG_RST = 7'd0;
  localparam logic [6:0] WIN_ROWS_RST    = 7'd25;
  localparam logic [7:0] WIN_COLS_RST    = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_COLS = 3'd0,
    CFG_WIN_ROW_ORG = 3'd1,
    CFG_WIN_COL_ORG = 3'd2,
    CFG_WIN_ROWS    = 3'd3,
    CFG_WIN_COLS    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } twcw_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              did_scroll;
  } twcw_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDATA,
    ST_PUT,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_BLANK,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    ASEL_CLEAR,
    ASEL_READ,
    ASEL_CURSOR,
    ASEL_SRC,
    ASEL_DST,
    ASEL_BOTTOM
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_BLANK,
    WSEL_CHAR,
    WSEL_MOVE
  } wdata_sel_e;

  typedef struct packed {
    logic       accept;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       mem_we;
    logic       mem_re;
    logic       cur_advance;
    logic       scr_start;
    logic       scr_step_move;
    logic       scr_step_blank;
    logic       clr_step;
    logic       load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_is_read;
    logic put_writes;
    logic put_scrolls;
    logic one_row;
    logic col_last;
    logic row_last;
    logic clr_last;
  } dp_sts_t;

endpackage

### design/twcw_ram.sv
module twcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/twcw_ctrl.sv
module twcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  twcw_pkg::dp_sts_t sts_i,
  output twcw_pkg::ctl_cmd_t cmd_o
);
  import twcw_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The result register can take a new value when it is empty or is being taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.addr_sel  = ASEL_CLEAR;
    cmd_o.wdata_sel = WSEL_BLANK;
    in_stall_o    = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PUT;
        end
      end
      ST_READ: begin
        cmd_o.addr_sel = ASEL_READ;
        cmd_o.mem_re   = 1'b1;
        state_d        = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PUT: begin
        if (sts_i.req_is_read) begin
          state_d = ST_READ;
        end else begin
          cmd_o.addr_sel    = ASEL_CURSOR;
          cmd_o.wdata_sel   = WSEL_CHAR;
          cmd_o.mem_we      = sts_i.put_writes;
          cmd_o.cur_advance = 1'b1;
          if (sts_i.put_scrolls) begin
            cmd_o.scr_start = 1'b1;
            state_d = sts_i.one_row ? ST_BLANK : ST_MOVE_RD;
          end else if (out_free) begin
            cmd_o.load_result = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MOVE_RD: begin
        cmd_o.addr_sel = ASEL_SRC;
        cmd_o.mem_re   = 1'b1;
        state_d        = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd_o.addr_sel      = ASEL_DST;
        cmd_o.wdata_sel     = WSEL_MOVE;
        cmd_o.mem_we        = 1'b1;
        cmd_o.scr_step_move = 1'b1;
        state_d = (sts_i.col_last && sts_i.row_last) ? ST_BLANK : ST_MOVE_RD;
      end
      ST_BLANK: begin
        cmd_o.addr_sel       = ASEL_BOTTOM;
        cmd_o.wdata_sel      = WSEL_BLANK;
        cmd_o.mem_we         = 1'b1;
        cmd_o.scr_step_blank = 1'b1;
        if (sts_i.col_last) begin
          if (out_free) begin
            cmd_o.load_result = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/twcw_dp.sv
module twcw_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  twcw_pkg::twcw_in_t                   in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [twcw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [twcw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  twcw_pkg::ctl_cmd_t                   cmd_i,
  output twcw_pkg::dp_sts_t                    sts_o,
  output twcw_pkg::twcw_out_t                  out_data_o
);
  import twcw_pkg::*;

  // Configuration registers.
  logic [7:0] screen_cols_q;
  logic [5:0] win_row_org_q;
  logic [6:0] win_col_org_q;
  logic [6:0] win_rows_q;
  logic [7:0] win_cols_q;

  // Cursor, scroll and clear counters.
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  sr_q, sr_d;
  logic [COL_W-1:0]  sc_q, sc_d;
  logic [ADDR_W-1:0] clr_q;
  logic              did_scroll_q, did_scroll_d;

  twcw_in_t  req_q;
  twcw_out_t res_q;

  logic [ROW_W:0]  rows;
  logic [COL_W:0]  cols;
  logic [ROW_W:0]  rows_m1;
  logic [COL_W:0]  cols_m1;
  logic [ROW_W:0]  row_inc;
  logic [COL_W:0]  col_inc;
  logic [COL_W:0]  sc_inc;
  logic [ROW_W:0]  sr_inc2;
  logic            row_end;
  logic            col_wrap;
  logic            is_newline;

  logic [ROW_W:0]  addr_row;
  logic [COL_W:0]  addr_col;
  logic [14:0]     addr_prod;
  logic [15:0]     addr_sum;
  logic [ADDR_W-1:0] mem_addr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;

  // Effective window size: zero acts as one, large values clip to the cursor reach.
  always_comb begin
    if (win_rows_q == '0) begin
      rows = 7'd1;
    end else if (win_rows_q > ROWS_LIMIT) begin
      rows = ROWS_LIMIT;
    end else begin
      rows = win_rows_q;
    end
    if (win_cols_q == '0) begin
      cols = 8'd1;
    end else if (win_cols_q > COLS_LIMIT) begin
      cols = COLS_LIMIT;
    end else begin
      cols = win_cols_q;
    end
  end

  assign rows_m1    = rows - 7'd1;
  assign cols_m1    = cols - 8'd1;
  assign is_newline = (req_q.char_code == NEWLINE_CODE);
  assign row_inc    = {1'b0, cur_row_q} + 7'd1;
  assign col_inc    = {1'b0, cur_col_q} + 8'd1;
  assign row_end    = (row_inc >= rows);
  assign col_wrap   = is_newline || (col_inc >= cols);
  assign sc_inc     = {1'b0, sc_q} + 8'd1;
  assign sr_inc2    = {1'b0, sr_q} + 7'd2;

  assign sts_o.req_is_read = req_q.op;
  assign sts_o.put_writes  = !is_newline;
  assign sts_o.put_scrolls = col_wrap && row_end;
  assign sts_o.one_row     = (rows == 7'd1);
  assign sts_o.col_last    = (sc_inc >= cols);
  assign sts_o.row_last    = (sr_inc2 >= rows);
  assign sts_o.clr_last    = &clr_q;

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (cmd_i.accept && !in_data_i.op) begin
      // Saturate a cursor left outside the window by a register write.
      if ({1'b0, cur_row_q} > rows_m1) begin
        cur_row_d = rows_m1[ROW_W-1:0];
      end
      if ({1'b0, cur_col_q} > cols_m1) begin
        cur_col_d = cols_m1[COL_W-1:0];
      end
    end else if (cmd_i.cur_advance) begin
      if (col_wrap) begin
        cur_col_d = '0;
        if (!row_end) begin
          cur_row_d = row_inc[ROW_W-1:0];
        end
      end else begin
        cur_col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    sr_d = sr_q;
    sc_d = sc_q;
    if (cmd_i.scr_start) begin
      sr_d = '0;
      sc_d = '0;
    end else if (cmd_i.scr_step_move) begin
      if (sts_o.col_last) begin
        sc_d = '0;
        if (!sts_o.row_last) begin
          sr_d = sr_q + 6'd1;
        end
      end else begin
        sc_d = sc_inc[COL_W-1:0];
      end
    end else if (cmd_i.scr_step_blank) begin
      sc_d = sc_inc[COL_W-1:0];
    end
  end

  always_comb begin
    did_scroll_d = did_scroll_q;
    if (cmd_i.accept) begin
      did_scroll_d = 1'b0;
    end else if (cmd_i.scr_start) begin
      did_scroll_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_cols_q <= SCREEN_COLS_RST;
      win_row_org_q <= WIN_ROW_ORG_RST;
      win_col_org_q <= WIN_COL_ORG_RST;
      win_rows_q    <= WIN_ROWS_RST;
      win_cols_q    <= WIN_COLS_RST;
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      sr_q          <= '0;
      sc_q          <= '0;
      clr_q         <= '0;
      did_scroll_q  <= 1'b0;
    end else begin
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      sr_q         <= sr_d;
      sc_q         <= sc_d;
      did_scroll_q <= did_scroll_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SCREEN_COLS: screen_cols_q <= cfg_data_i;
          CFG_WIN_ROW_ORG: win_row_org_q <= cfg_data_i[5:0];
          CFG_WIN_COL_ORG: win_col_org_q <= cfg_data_i[6:0];
          CFG_WIN_ROWS:    win_rows_q    <= cfg_data_i[6:0];
          CFG_WIN_COLS:    win_cols_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_result) begin
      res_q.cell_char  <= req_q.op ? mem_rdata : '0;
      res_q.cursor_row <= cur_row_d;
      res_q.cursor_col <= cur_col_d;
      res_q.did_scroll <= did_scroll_d;
    end
  end

  // Cell address: row times screen stride plus column, wrapped to the store.
  always_comb begin
    addr_row = '0;
    addr_col = '0;
    case (cmd_i.addr_sel)
      ASEL_READ: begin
        addr_row = {1'b0, req_q.read_row};
        addr_col = {1'b0, req_q.read_col};
      end
      ASEL_CURSOR: begin
        addr_row = {1'b0, win_row_org_q} + {1'b0, cur_row_q};
        addr_col = {1'b0, win_col_org_q} + {1'b0, cur_col_q};
      end
      ASEL_SRC: begin
        addr_row = {1'b0, win_row_org_q} + {1'b0, sr_q} + 7'd1;
        addr_col = {1'b0, win_col_org_q} + {1'b0, sc_q};
      end
      ASEL_DST: begin
        addr_row = {1'b0, win_row_org_q} + {1'b0, sr_q};
        addr_col = {1'b0, win_col_org_q} + {1'b0, sc_q};
      end
      ASEL_BOTTOM: begin
        addr_row = {1'b0, win_row_org_q} + rows_m1;
        addr_col = {1'b0, win_col_org_q} + {1'b0, sc_q};
      end
      default: begin
        addr_row = '0;
        addr_col = '0;
      end
    endcase
  end

  assign addr_prod = addr_row * screen_cols_q;
  assign addr_sum  = {1'b0, addr_prod} + {8'd0, addr_col};
  assign mem_addr  = (cmd_i.addr_sel == ASEL_CLEAR) ? clr_q : addr_sum[ADDR_W-1:0];

  always_comb begin
    case (cmd_i.wdata_sel)
      WSEL_CHAR: mem_wdata = req_q.char_code;
      WSEL_MOVE: mem_wdata = mem_rdata;
      default:   mem_wdata = BLANK_CODE;
    endcase
  end

  twcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (cmd_i.mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign out_data_o = res_q;

endmodule

### design/text_window_char_writer.sv
// Text window character writer. The block owns a 64 x 128 character screen store and
// writes characters into one rectangular window of it; a newline sends the cursor to the
// window's first column on the next row, other bytes are stored at the cursor, and
// moving past the last window row scrolls only the window's columns up by one row and
// blanks its bottom row. A read transaction returns any screen cell. After reset the
// store is filled with spaces by a clearing pass, one cell per cycle, during which
// in_stall_o stays high; configuration writes are taken at any time but must only be
// issued while the block is idle. The store's read and write ports share one address,
// so a put that scrolls moves each cell of the window below its top row up one row
// through a read state and then a write state, and afterwards blanks the bottom row.
// A finished result waits in an output register, so the next transaction can be
// accepted while the previous result is still stalled.
module text_window_char_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  twcw_pkg::twcw_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output twcw_pkg::twcw_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [twcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [twcw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import twcw_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Register writes never wait, so the port is always ready.
  assign cfg_ready_o = 1'b1;

  // The controller sequences clearing, puts, reads and scroll sweeps.
  twcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, cursor, counters, store and result register.
  twcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // A result is never loaded over one that is still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_result |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // The store is never written in a cycle in which a transaction may be accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.mem_we)
    else $error("store written while accepting input");

  // At most one of the counter steps and the accept happens in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.scr_step_move, cmd.scr_step_blank, cmd.clr_step}))
    else $error("conflicting sequencer commands");

  // After a transaction is accepted the block stalls input until it has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after acceptance");
`endif

endmodule
